// ===== hdl/rlc_pkg.sv =====
// Shared types, constants and command/status bundles for the byte RLE codec.
// No dependencies; used by rlc_ctrl, rlc_dp and byte_rle_codec.
`timescale 1ns / 1ps

package rlc_pkg;

  // Longest run held in one count byte (default for the MAX_RUN parameter)
  localparam int MAX_RUN_DEF = 255;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;
  localparam logic [15:0] LIMIT_RESET = 16'd4096;

  // Kinds of result the datapath can build
  localparam logic [1:0] EMIT_PAIR   = 2'd0;
  localparam logic [1:0] EMIT_ABORT  = 2'd1;
  localparam logic [1:0] EMIT_MARKER = 2'd2;
  localparam logic [1:0] EMIT_WORD   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } rlc_in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [2:0]  out_valid_bytes;
    logic        frame_done;
    logic        overflow;
  } rlc_out_t;

  // Controller -> datapath
  typedef struct packed {
    logic       load_in;      // capture the accepted input item
    logic       emit;         // load the output register
    logic [1:0] emit_kind;
    logic       emit_done;    // frame_done of the emitted result
    logic       clr_frame;    // drop all frame state
    logic       set_failed;   // discard the rest of the frame
    logic       run_start;    // open a run with the held byte
    logic       run_inc;      // extend the open run
    logic       len_add2;     // account for an emitted pair
    logic       take_count;   // store a count byte
    logic       start_expand; // commit a pair's length, load the byte counter
    logic       rem_step;     // one decoded word sent
  } rlc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic mode;
    logic fe;
    logic failed;
    logic expect_value;
    logic brk;
    logic run_open;
    logic pair_ovf;
    logic exp_ovf;
    logic rem_zero;
    logic rem_last;
    logic slot_free;
  } rlc_stat_t;

endpackage

// ===== hdl/byte_rle_codec.sv =====
// Top level of the byte run-length codec ([count][value] pairs).
// Instantiates rlc_ctrl and rlc_dp; uses rlc_pkg.
//
// Usage:
//   in_valid/in_ready/in_data carry one byte and its frame_end flag per
//   transfer. out_valid/out_ready/out_data carry result words. cfg_we with
//   cfg_index 0 writes decode_mode (0 encode, 1 decode; the write drops
//   any open frame), cfg_index 1 writes frame_limit. Write config only
//   while the block is idle.
//   Sequencing: one item at a time through the controller. An encode byte
//   passes S_CHK, S_ENC_BRK, S_ENC_FE before in_ready returns, a decode
//   count byte S_CHK, S_DEC, a decode value byte S_CHK, S_DEC, S_DEC_RUN
//   (one output word per cycle from the expansion counter while the output
//   register is free). Each result sits in the output register from the
//   cycle after it is formed; the next byte can transfer while it waits.
//   Stall: when a new result is due and the output register is full with
//   out_ready low, the controller holds in its state until it frees.
//   Reset (rst, synchronous): encode mode, frame_limit 4096, no frame
//   open, output empty.
`timescale 1ns / 1ps

module byte_rle_codec import rlc_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rlc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlc_out_t             out_data
);

  rlc_cmd_t  cmd;
  rlc_stat_t stat;

  rlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rlc_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/rlc_dp.sv =====
// Datapath of the byte RLE codec: config registers, run/frame state,
// byte counter for expansion and the output register. Uses rlc_pkg.
`timescale 1ns / 1ps

module rlc_dp import rlc_pkg::*; #(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  rlc_in_t              in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output rlc_out_t             out_data,
  input  rlc_cmd_t             cmd,
  output rlc_stat_t            stat
);

  localparam logic [7:0] RUN_CAP = 8'(MAX_RUN);

  // Config registers
  logic        mode;
  logic [15:0] limit;

  // Held input item
  logic [7:0] b;
  logic       fe;

  // Frame state
  logic [7:0]  run_value;
  logic [7:0]  run_length;
  logic        expect_value;
  logic [7:0]  pending;
  logic [15:0] out_len;
  logic        failed;
  logic [7:0]  rem;

  logic [16:0] need2;
  logic [16:0] total;
  logic [2:0]  k;
  logic [31:0] word;
  rlc_out_t    res;

  // Limit checks and word size
  assign need2 = {1'b0, out_len} + 17'd2;
  assign total = {1'b0, out_len} + {9'b0, pending};
  assign k     = (rem <= 8'd4) ? rem[2:0] : 3'd4;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      word[8*i +: 8] = (3'(i) < k) ? b : 8'd0;
    end
  end

  // Status to the controller
  always_comb begin
    stat.mode         = mode;
    stat.fe           = fe;
    stat.failed       = failed;
    stat.expect_value = expect_value;
    stat.run_open     = (run_length != 8'd0);
    stat.brk          = (run_length != 8'd0) && ((b != run_value) || (run_length >= RUN_CAP));
    stat.pair_ovf     = need2 > {1'b0, limit};
    stat.exp_ovf      = total > {1'b0, limit};
    stat.rem_zero     = (rem == 8'd0);
    stat.rem_last     = (rem <= 8'd4);
    stat.slot_free    = !out_valid || out_ready;
  end

  // Result selection
  always_comb begin
    res = '0;
    res.frame_done = cmd.emit_done;
    case (cmd.emit_kind)
      EMIT_PAIR: begin
        res.out_word        = {16'd0, run_value, run_length};
        res.out_valid_bytes = 3'd2;
      end
      EMIT_ABORT: begin
        res.frame_done = 1'b1;
        res.overflow   = 1'b1;
      end
      EMIT_MARKER: begin
        res.frame_done = 1'b1;
      end
      EMIT_WORD: begin
        res.out_word        = word;
        res.out_valid_bytes = k;
      end
      default: res = '0;
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode  <= cfg_data[0];
        REG_LIMIT: limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      b  <= in_data.data_byte;
      fe <= in_data.frame_end;
    end
  end

  // Frame state; reset, a mode write, a frame end or an overflow abort clears it
  always_ff @(posedge clk) begin
    if (rst || (cfg_we && cfg_index == REG_MODE)) begin
      run_value    <= 8'd0;
      run_length   <= 8'd0;
      expect_value <= 1'b0;
      pending      <= 8'd0;
      out_len      <= 16'd0;
      failed       <= 1'b0;
      rem          <= 8'd0;
    end else begin
      if (cmd.run_start) begin
        run_value  <= b;
        run_length <= 8'd1;
      end
      if (cmd.run_inc) begin
        run_length <= run_length + 8'd1;
      end
      if (cmd.len_add2) begin
        out_len <= need2[15:0];
      end
      if (cmd.take_count) begin
        pending      <= b;
        expect_value <= 1'b1;
      end
      if (cmd.start_expand) begin
        expect_value <= 1'b0;
        out_len      <= total[15:0];
        rem          <= pending;
      end
      if (cmd.rem_step) begin
        rem <= rem - {5'd0, k};
      end
      if (cmd.clr_frame) begin
        run_value    <= 8'd0;
        run_length   <= 8'd0;
        expect_value <= 1'b0;
        pending      <= 8'd0;
        out_len      <= 16'd0;
        failed       <= 1'b0;
        rem          <= 8'd0;
      end
      if (cmd.set_failed) begin
        failed <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= res;
    end
  end

endmodule

// ===== hdl/rlc_ctrl.sv =====
// Controller of the byte RLE codec: sequences one input item at a time
// and drives datapath commands. Uses rlc_pkg.
`timescale 1ns / 1ps

module rlc_ctrl import rlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rlc_stat_t stat,
  output rlc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CHK     = 3'd1;
  localparam logic [2:0] S_ENC_BRK = 3'd2;
  localparam logic [2:0] S_ENC_FE  = 3'd3;
  localparam logic [2:0] S_DEC     = 3'd4;
  localparam logic [2:0] S_DEC_RUN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.failed) begin
          cmd.clr_frame = stat.fe;
          state_next    = S_IDLE;
        end else if (stat.mode) begin
          state_next = S_DEC;
        end else begin
          state_next = S_ENC_BRK;
        end
      end
      // close the open run if the byte breaks it or it is full, else open or extend the run
      S_ENC_BRK: begin
        if (stat.brk) begin
          if (stat.slot_free) begin
            cmd.emit = 1'b1;
            if (stat.pair_ovf) begin
              cmd.emit_kind  = EMIT_ABORT;
              cmd.clr_frame  = 1'b1;
              cmd.set_failed = !stat.fe;
              state_next     = S_IDLE;
            end else begin
              cmd.emit_kind = EMIT_PAIR;
              cmd.len_add2  = 1'b1;
              cmd.run_start = 1'b1;
              state_next    = S_ENC_FE;
            end
          end
        end else begin
          cmd.run_inc   = stat.run_open;
          cmd.run_start = !stat.run_open;
          state_next    = S_ENC_FE;
        end
      end
      // flush the run at frame end
      S_ENC_FE: begin
        if (!stat.fe) begin
          state_next = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = stat.pair_ovf ? EMIT_ABORT : EMIT_PAIR;
          cmd.emit_done = 1'b1;
          cmd.clr_frame = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_DEC: begin
        if (!stat.expect_value) begin
          // count byte; one carrying frame end is dropped
          if (!stat.fe) begin
            cmd.take_count = 1'b1;
            state_next     = S_IDLE;
          end else if (stat.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EMIT_MARKER;
            cmd.clr_frame = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (stat.exp_ovf) begin
          if (stat.slot_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_kind  = EMIT_ABORT;
            cmd.clr_frame  = 1'b1;
            cmd.set_failed = !stat.fe;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.start_expand = 1'b1;
          state_next       = S_DEC_RUN;
        end
      end
      // one word of up to four bytes per cycle while the output register is free
      S_DEC_RUN: begin
        if (stat.rem_zero) begin
          if (!stat.fe) begin
            state_next = S_IDLE;
          end else if (stat.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = EMIT_MARKER;
            cmd.clr_frame = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EMIT_WORD;
          cmd.emit_done = stat.fe && stat.rem_last;
          cmd.rem_step  = 1'b1;
          if (stat.rem_last) begin
            cmd.clr_frame = stat.fe;
            state_next    = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.slot_free)
    else $error("result loaded into a busy output register");

  // An accepted item is always evaluated next
  a_accept_chk: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_CHK))
    else $error("accepted item not evaluated");

  // Expansion keeps going until the final word
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC_RUN && cmd.emit && !stat.rem_last && !stat.rem_zero)
      |=> (state == S_DEC_RUN))
    else $error("expansion ended early");

  // Failing a frame only comes with an overflow result
  a_fail_abort: assert property (@(posedge clk) disable iff (rst)
    cmd.set_failed |-> (cmd.emit && cmd.clr_frame && cmd.emit_kind == EMIT_ABORT))
    else $error("frame failed without overflow result");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for byte_rle_codec: encode and decode frames, overflow, config.
// Depends on rlc_pkg (payload structs, register indexes) and the byte_rle_codec RTL.
`timescale 1ns / 1ps

module tb;
  import rlc_pkg::*;

  localparam int DRAIN_CYCLES = 100;  // longest expansion plus pipeline, with margin

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MODE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  rlc_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rlc_out_t out_data;

  // Stimulus and expectation stores
  rlc_in_t byte_queue[$];
  rlc_out_t expected_words[$];
  rlc_out_t oldest_word;

  int send_idle_pct = 12;
  int recv_idle_pct = 69;
  int bytes_sent = 0;
  int words_checked = 0;
  int fail_count = 0;

  // Predictor copy of config and frame state
  logic mode_decode;
  logic [15:0] limit_bytes;
  logic [7:0] run_byte;
  logic [7:0] run_len;
  logic want_value;
  logic [7:0] held_count;
  logic [15:0] frame_len;
  logic frame_dead;

  byte_rle_codec uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("byte_rle_codec regression: fail");
    $finish;
  end

  function automatic void drop_frame();
    run_byte = '0;
    run_len = '0;
    want_value = 1'b0;
    held_count = '0;
    frame_len = '0;
    frame_dead = 1'b0;
  endfunction

  function automatic void expect_word(logic [31:0] w, logic [2:0] nb, logic done, logic ovf);
    rlc_out_t r;
    r.out_word = w;
    r.out_valid_bytes = nb;
    r.frame_done = done;
    r.overflow = ovf;
    expected_words.push_back(r);
  endfunction

  // Overflow result; frame is discarded until frame_end unless this byte ends it
  function automatic void abort_frame(logic fe);
    expect_word('0, 3'd0, 1'b1, 1'b1);
    drop_frame();
    if (!fe) frame_dead = 1'b1;
  endfunction

  // Emit the open run as [count][value]; 0 when the length limit would be passed
  function automatic bit emit_run_pair(logic done);
    logic [16:0] need;
    need = {1'b0, frame_len} + 17'd2;
    if (need > {1'b0, limit_bytes}) return 1'b0;
    frame_len = need[15:0];
    expect_word({16'h0, run_byte, run_len}, 3'd2, done, 1'b0);
    return 1'b1;
  endfunction

  // Expected results for one transferred input byte
  function automatic void predict_codec_byte(logic [7:0] b, logic fe);
    logic [16:0] total;
    int rem;
    int k;
    logic [31:0] w;
    if (frame_dead) begin
      if (fe) drop_frame();
      return;
    end
    if (!mode_decode) begin
      // encode: close the run on a new byte or a full count
      if (run_len != 0 && (b != run_byte || run_len >= MAX_RUN_DEF)) begin
        if (!emit_run_pair(1'b0)) begin
          abort_frame(fe);
          return;
        end
        run_len = '0;
      end
      if (run_len == 0) begin
        run_byte = b;
        run_len = 8'd1;
      end else begin
        run_len = run_len + 8'd1;
      end
      if (fe) begin
        if (!emit_run_pair(1'b1)) begin
          abort_frame(fe);
          return;
        end
        drop_frame();
      end
      return;
    end
    // decode: count byte first
    if (!want_value) begin
      held_count = b;
      want_value = 1'b1;
      if (fe) begin
        // odd trailing byte is dropped, bare marker closes the frame
        expect_word('0, 3'd0, 1'b1, 1'b0);
        drop_frame();
      end
      return;
    end
    want_value = 1'b0;
    total = {1'b0, frame_len} + {9'h0, held_count};
    if (total > {1'b0, limit_bytes}) begin
      abort_frame(fe);
      return;
    end
    frame_len = total[15:0];
    rem = held_count;
    while (rem != 0) begin
      k = (rem > 4) ? 4 : rem;
      w = '0;
      for (int i = 0; i < k; i++) w[8*i +: 8] = b;
      expect_word(w, k[2:0], fe && (rem == k), 1'b0);
      rem -= k;
    end
    if (fe) begin
      if (held_count == 0) expect_word('0, 3'd0, 1'b1, 1'b0);
      drop_frame();
    end
  endfunction

  // Driver: predicts at each input transfer, then presents the next byte or idles
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        predict_codec_byte(in_data.data_byte, in_data.frame_end);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= byte_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          $error("unexpected result word %h (%0d bytes)", out_data.out_word,
                 out_data.out_valid_bytes);
          fail_count++;
        end else begin
          oldest_word = expected_words.pop_front();
          if (out_data.out_word !== oldest_word.out_word) begin
            $error("out_word: expected %h, got %h", oldest_word.out_word, out_data.out_word);
            fail_count++;
          end
          if (out_data.out_valid_bytes !== oldest_word.out_valid_bytes) begin
            $error("out_valid_bytes: expected %0d, got %0d", oldest_word.out_valid_bytes,
                   out_data.out_valid_bytes);
            fail_count++;
          end
          if (out_data.frame_done !== oldest_word.frame_done) begin
            $error("frame_done: expected %b, got %b", oldest_word.frame_done,
                   out_data.frame_done);
            fail_count++;
          end
          if (out_data.overflow !== oldest_word.overflow) begin
            $error("overflow: expected %b, got %b", oldest_word.overflow, out_data.overflow);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic fe);
    rlc_in_t item;
    item.data_byte = b;
    item.frame_end = fe;
    byte_queue.push_back(item);
  endtask

  // Register write; the block is idle whenever this is called
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) begin
      mode_decode = val[0];
      drop_frame();
    end else begin
      limit_bytes = val;
    end
  endtask

  // Wait until all bytes went in and all results came out, then let the block settle
  task automatic wait_idle();
    while (byte_queue.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Raw byte frames built from short runs, frame_end on the last byte
  task automatic queue_encode_frames(input int n_bytes);
    int added;
    int frame_bytes;
    int left;
    logic [7:0] val;
    added = 0;
    val = 8'h00;
    left = 0;
    while (added < n_bytes) begin
      frame_bytes = $urandom_range(1, 10);
      for (int i = 0; i < frame_bytes; i++) begin
        if (left == 0) begin
          if ($urandom_range(3) != 0) val = 8'($urandom());
          left = $urandom_range(1, 5);
        end
        queue_byte(val, i == frame_bytes - 1);
        left--;
      end
      added += frame_bytes;
    end
  endtask

  // [count][value] frames; counts mostly small, some full range, some odd tails
  task automatic queue_decode_frames(input int n_bytes);
    int added;
    int n_pairs;
    bit odd_tail;
    int sel;
    logic [7:0] cnt;
    added = 0;
    while (added < n_bytes) begin
      n_pairs = $urandom_range(1, 3);
      odd_tail = ($urandom_range(7) == 0);
      for (int p = 0; p < n_pairs; p++) begin
        sel = $urandom_range(7);
        if (sel == 0) cnt = 8'd0;
        else if (sel == 1) cnt = 8'($urandom_range(0, 255));
        else cnt = 8'($urandom_range(1, 9));
        queue_byte(cnt, 1'b0);
        queue_byte(8'($urandom()), (p == n_pairs - 1) && !odd_tail);
        added += 2;
      end
      if (odd_tail) begin
        queue_byte(8'($urandom()), 1'b1);
        added++;
      end
    end
  endtask

  initial begin
    mode_decode = 1'b0;
    limit_bytes = LIMIT_RESET;
    drop_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Encode, widest limit: single byte, runs, MAX_RUN split
    write_reg(REG_LIMIT, 16'hFFFF);
    write_reg(REG_MODE, {15'($urandom()), 1'b0});
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'hAA, 1'b1);
    queue_encode_frames(40);
    for (int i = 0; i < 256; i++) queue_byte(8'h3C, i == 255);
    // leave a run open across the limit write
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h81, 1'b0);
    wait_idle();

    // Encode, smallest limit: second pair overflows, overflow on frame end
    write_reg(REG_LIMIT, 16'd2);
    queue_byte(8'h11, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'h03, 1'b1);
    queue_byte(8'h07, 1'b1);
    queue_byte(8'h08, 1'b0);
    queue_byte(8'h09, 1'b1);
    queue_byte(8'h5A, 1'b0);
    queue_byte(8'h5A, 1'b1);
    queue_encode_frames(20);
    queue_byte(8'h42, 1'b0);
    wait_idle();

    // Decode: zero count, split words, odd tail, largest count
    send_idle_pct = 69;
    recv_idle_pct = 12;
    write_reg(REG_MODE, {15'($urandom()), 1'b1});
    write_reg(REG_LIMIT, LIMIT_RESET);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'h5A, 1'b1);
    queue_byte(8'd5, 1'b0);
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'd4, 1'b0);
    queue_byte(8'hCD, 1'b1);
    queue_byte(8'd7, 1'b1);
    queue_byte(8'd255, 1'b0);
    queue_byte(8'hE7, 1'b1);
    queue_byte(8'd0, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'd3, 1'b0);
    queue_byte(8'h81, 1'b1);
    queue_decode_frames(30);
    wait_idle();

    // Decode overflow: mid-frame abort, discard, abort on frame end, exact fit
    write_reg(REG_LIMIT, 16'd16);
    queue_byte(8'd10, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'd10, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(8'd1, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'd2, 1'b0);
    queue_byte(8'h44, 1'b1);
    queue_byte(8'd20, 1'b0);
    queue_byte(8'h55, 1'b1);
    queue_byte(8'd16, 1'b0);
    queue_byte(8'h66, 1'b1);
    queue_decode_frames(15);
    // pending count left open across the limit write below
    queue_byte(8'd9, 1'b0);
    wait_idle();

    // No idling from here on
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_LIMIT, 16'd2);
    queue_decode_frames(15);
    wait_idle();

    write_reg(REG_MODE, {15'($urandom()), 1'b0});
    write_reg(REG_LIMIT, 16'($urandom_range(2, 40)));
    queue_encode_frames(20);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h77, 1'b0);
    wait_idle();

    $display("Sent %0d bytes through encode and decode frames, checked %0d result words.",
             bytes_sent, words_checked);
    $display("Limits from 2 to 65535, overflow aborts, zero counts and odd tails included.");
    if (fail_count == 0) begin
      $display("byte_rle_codec regression: pass");
    end else begin
      $display("byte_rle_codec regression: fail");
    end
    $finish;
  end

endmodule
